[rtl/core/rfp_pkg.sv]
package rfp_pkg;

   // largest frame length accepted
   localparam int unsigned MAX_FRAME = 4096;
   // width of frame positions, lengths and field counts
   localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);
   // start, length, three length words, error code, checksum and end
   localparam int unsigned FIXED_BYTES = 26;
   // bytes of fixed tail still needed after each length word
   localparam int unsigned TAIL_AFTER_IDLEN = 17;
   localparam int unsigned TAIL_AFTER_SVCLEN = 13;
   localparam int unsigned TAIL_AFTER_INFOLEN = 5;
   // fixed tail bytes after the payload (checksum and end), plus one
   localparam int unsigned PAY_TAIL = 6;
   localparam int unsigned WORD_BYTES = 4;

   localparam logic [7:0] START_MARKER_RST = 8'h02;
   localparam logic [7:0] END_MARKER_RST = 8'h03;

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_LEN     = 4'd1,
      PH_IDLEN   = 4'd2,
      PH_ID      = 4'd3,
      PH_SVCLEN  = 4'd4,
      PH_SVC     = 4'd5,
      PH_ERR     = 4'd6,
      PH_INFOLEN = 4'd7,
      PH_INFO    = 4'd8,
      PH_PAY     = 4'd9,
      PH_CSUM    = 4'd10,
      PH_END     = 4'd11,
      PH_DRAIN   = 4'd12
   } phase_type;

   typedef enum logic [3:0] {
      TAG_START   = 4'd0,
      TAG_LEN     = 4'd1,
      TAG_IDLEN   = 4'd2,
      TAG_ID      = 4'd3,
      TAG_SVCLEN  = 4'd4,
      TAG_SVC     = 4'd5,
      TAG_ERRCODE = 4'd6,
      TAG_INFOLEN = 4'd7,
      TAG_INFO    = 4'd8,
      TAG_PAY     = 4'd9,
      TAG_CSUM    = 4'd10,
      TAG_END     = 4'd11,
      TAG_SKIP    = 4'd12
   } tag_type;

   typedef enum logic [2:0] {
      ST_PROGRESS = 3'd0,
      ST_OK       = 3'd1,
      ST_NO_END   = 3'd2,
      ST_EMPTY_ID = 3'd3,
      ST_OVERRUN  = 3'd4,
      ST_BAD_LEN  = 3'd5
   } status_type;

   typedef enum logic {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

endpackage

[rtl/core/rpc_frame_parser.sv]
// channel   ports                                         direction
// --------  --------------------------------------------  ---------
// request   req_valid, req_ready, req_in_byte             in
// response  rsp_valid, rsp_ready, rsp_out_byte,           out
//           rsp_field_tag, rsp_frame_last, rsp_frame_status
// config    csr_we, csr_index, csr_wdata                  in
//
// one byte per cycle while the response is not stalled: a byte is parsed against
// the frame state in the cycle it is offered, and its response is loaded into the
// output register at the edge that accepts it.
// reset is synchronous and active high; it returns the parser to hunting for
// the start marker and the markers to their defaults.
// a stalled response holds the output register; no new byte is taken until it goes
module rpc_frame_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic [3:0]                rsp_field_tag,
   output logic                      rsp_frame_last,
   output logic [2:0]                rsp_frame_status,
   input  logic                      csr_we,
   input  rfp_pkg::csr_index_type    csr_index,
   input  logic [7:0]                csr_wdata
);
   import rfp_pkg::*;

   // configuration
   logic [7:0] start_marker_ff;
   logic [7:0] end_marker_ff;

   // frame state
   phase_type  phase_ff, phase_in;
   pos_type    pos_ff, pos_in;
   pos_type    len_ff, len_in;
   logic [31:0] accum_ff, accum_in;
   pos_type    rem_ff, rem_in;
   status_type err_ff, err_in;

   // response register
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   tag_type    tag_ff, tag_in;
   logic       last_ff, last_in;
   status_type status_ff, status_in;

   // parse working values
   logic        accept;
   pos_type     idx;
   pos_type     rem_dec;
   logic [31:0] word_val;
   logic        word_done;
   pos_type     pay_len;
   pos_type     slack_idlen;
   pos_type     slack_svclen;
   pos_type     slack_infolen;
   logic [POS_W:0] idx_next;

   assign accept = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // position of this byte in the frame; a hunted byte counts as the first
   assign idx = (phase_ff == PH_HUNT) ? '0 : pos_ff;

   // bytes still unclaimed after idx once the fixed tail is set aside
   assign slack_idlen   = len_ff - idx - POS_W'(1 + TAIL_AFTER_IDLEN);
   assign slack_svclen  = len_ff - idx - POS_W'(1 + TAIL_AFTER_SVCLEN);
   assign slack_infolen = len_ff - idx - POS_W'(1 + TAIL_AFTER_INFOLEN);
   assign pay_len       = len_ff - idx - POS_W'(PAY_TAIL);
   assign idx_next      = {1'b0, idx} + (POS_W+1)'(1);
   assign rem_dec       = rem_ff - POS_W'(1);
   assign word_val      = {accum_ff[23:0], req_in_byte};

   // next state and response for the byte on the request port
   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      accum_in  = accum_ff;
      rem_in    = rem_ff;
      err_in    = err_ff;
      tag_in    = TAG_SKIP;
      last_in   = 1'b0;
      status_in = ST_PROGRESS;
      word_done = 1'b0;

      case (phase_ff)
         PH_HUNT: begin
            if (req_in_byte == start_marker_ff) begin
               tag_in   = TAG_START;
               err_in   = ST_PROGRESS;
               len_in   = '0;
               phase_in = PH_LEN;
               rem_in   = POS_W'(WORD_BYTES);
               accum_in = '0;
            end
         end
         PH_LEN, PH_IDLEN, PH_SVCLEN, PH_ERR, PH_INFOLEN, PH_CSUM: begin
            case (phase_ff)
               PH_LEN:     tag_in = TAG_LEN;
               PH_IDLEN:   tag_in = TAG_IDLEN;
               PH_SVCLEN:  tag_in = TAG_SVCLEN;
               PH_ERR:     tag_in = TAG_ERRCODE;
               PH_INFOLEN: tag_in = TAG_INFOLEN;
               default:    tag_in = TAG_CSUM;
            endcase
            accum_in  = word_val;
            rem_in    = rem_dec;
            word_done = (rem_dec == '0);
         end
         PH_ID, PH_SVC, PH_INFO, PH_PAY: begin
            rem_in = rem_dec;
            case (phase_ff)
               PH_ID:   tag_in = TAG_ID;
               PH_SVC:  tag_in = TAG_SVC;
               PH_INFO: tag_in = TAG_INFO;
               default: tag_in = TAG_PAY;
            endcase
            if (rem_dec == '0) begin
               rem_in   = POS_W'(WORD_BYTES);
               accum_in = '0;
               case (phase_ff)
                  PH_ID:   phase_in = PH_SVCLEN;
                  PH_SVC:  phase_in = PH_ERR;
                  PH_INFO: begin
                     if (pay_len != '0) begin
                        phase_in = PH_PAY;
                        rem_in   = pay_len;
                     end else begin
                        phase_in = PH_CSUM;
                     end
                  end
                  default: phase_in = PH_CSUM;
               endcase
            end
         end
         PH_END: begin
            tag_in   = TAG_END;
            last_in  = 1'b1;
            phase_in = PH_HUNT;
            if (err_ff != ST_PROGRESS) begin
               status_in = err_ff;
            end else if (req_in_byte == end_marker_ff) begin
               status_in = ST_OK;
            end else begin
               status_in = ST_NO_END;
            end
         end
         default: begin
            // draining an overrun frame up to its declared length
            if (idx_next >= {1'b0, len_ff}) begin
               tag_in    = TAG_END;
               last_in   = 1'b1;
               status_in = err_ff;
               phase_in  = PH_HUNT;
            end
         end
      endcase

      // a length, code or checksum word has just completed
      if (word_done) begin
         case (phase_ff)
            PH_LEN: begin
               if (word_val < 32'(FIXED_BYTES) || word_val > 32'(MAX_FRAME)) begin
                  last_in   = 1'b1;
                  status_in = ST_BAD_LEN;
                  phase_in  = PH_HUNT;
               end else begin
                  len_in   = word_val[POS_W-1:0];
                  phase_in = PH_IDLEN;
                  rem_in   = POS_W'(WORD_BYTES);
                  accum_in = '0;
               end
            end
            PH_IDLEN: begin
               if (word_val == '0 && err_in == ST_PROGRESS) begin
                  err_in = ST_EMPTY_ID;
               end
               if (word_val > 32'(slack_idlen)) begin
                  if (err_in == ST_PROGRESS) err_in = ST_OVERRUN;
                  phase_in = PH_DRAIN;
               end else if (word_val != '0) begin
                  phase_in = PH_ID;
                  rem_in   = word_val[POS_W-1:0];
               end else begin
                  phase_in = PH_SVCLEN;
                  rem_in   = POS_W'(WORD_BYTES);
                  accum_in = '0;
               end
            end
            PH_SVCLEN: begin
               if (word_val > 32'(slack_svclen)) begin
                  if (err_in == ST_PROGRESS) err_in = ST_OVERRUN;
                  phase_in = PH_DRAIN;
               end else if (word_val != '0) begin
                  phase_in = PH_SVC;
                  rem_in   = word_val[POS_W-1:0];
               end else begin
                  phase_in = PH_ERR;
                  rem_in   = POS_W'(WORD_BYTES);
                  accum_in = '0;
               end
            end
            PH_ERR: begin
               phase_in = PH_INFOLEN;
               rem_in   = POS_W'(WORD_BYTES);
               accum_in = '0;
            end
            PH_INFOLEN: begin
               if (word_val > 32'(slack_infolen)) begin
                  if (err_in == ST_PROGRESS) err_in = ST_OVERRUN;
                  phase_in = PH_DRAIN;
               end else if (word_val != '0) begin
                  phase_in = PH_INFO;
                  rem_in   = word_val[POS_W-1:0];
               end else if (pay_len != '0) begin
                  phase_in = PH_PAY;
                  rem_in   = pay_len;
               end else begin
                  phase_in = PH_CSUM;
                  rem_in   = POS_W'(WORD_BYTES);
                  accum_in = '0;
               end
            end
            default: phase_in = PH_END;
         endcase
      end

      pos_in = (phase_in == PH_HUNT) ? '0 : idx_next[POS_W-1:0];
   end

   // marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame state advances on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         len_ff   <= '0;
         accum_ff <= '0;
         rem_ff   <= '0;
         err_ff   <= ST_PROGRESS;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         accum_ff <= accum_in;
         rem_ff   <= rem_in;
         err_ff   <= err_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff <= req_in_byte;
         tag_ff      <= tag_in;
         last_ff     <= last_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_field_tag    = tag_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_frame_status = status_ff;

endmodule

[dv/rfp_echo_checker.sv]
`timescale 1ns / 1ps
module rfp_echo_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_out_byte,
   input  logic [3:0]             rsp_field_tag,
   input  logic                   rsp_frame_last,
   input  logic [2:0]             rsp_frame_status,
   input  logic                   csr_we,
   input  rfp_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata,
   output int unsigned            error_count,
   output int unsigned            pending
);
   import rfp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      tag_type    tag;
      logic       last;
      status_type status;
   } echo_type;

   // own copy of the parser state and the marker registers
   phase_type   phase;
   status_type  err_latch;
   logic [31:0] pos;
   logic [31:0] flen;
   logic [31:0] accum;
   logic [31:0] remain;
   logic [7:0]  start_mk;
   logic [7:0]  end_mk;
   echo_type    expected_echoes[$];

   function automatic void start_word(input phase_type next);
      phase = next;
      remain = WORD_BYTES;
      accum = '0;
   endfunction

   // a zero-length field is skipped straight to the word that follows it
   function automatic void open_field(input phase_type body, input logic [31:0] len,
                                      input phase_type next_word);
      if (len != 0) begin
         phase = body;
         remain = len;
      end else begin
         start_word(next_word);
      end
   endfunction

   // bytes still free after idx once the fixed tail is set aside
   function automatic logic [31:0] room_after(input logic [31:0] idx,
                                              input int unsigned tail);
      return flen - idx - 1 - tail;
   endfunction

   function automatic void mark_overrun();
      if (err_latch == ST_PROGRESS) err_latch = ST_OVERRUN;
      phase = PH_DRAIN;
   endfunction

   // predicted echo for one received byte, advancing the frame state
   function automatic echo_type parse_byte(input logic [7:0] b);
      echo_type    e;
      logic [31:0] idx;
      logic [31:0] v;
      logic        word_done;
      e.data = b;
      e.tag = TAG_SKIP;
      e.last = 1'b0;
      e.status = ST_PROGRESS;
      idx = pos;
      word_done = 1'b0;

      case (phase)
         PH_HUNT: begin
            if (b == start_mk) begin
               e.tag = TAG_START;
               err_latch = ST_PROGRESS;
               flen = '0;
               start_word(PH_LEN);
            end
            idx = '0;
         end
         PH_LEN, PH_IDLEN, PH_SVCLEN, PH_ERR, PH_INFOLEN, PH_CSUM: begin
            case (phase)
               PH_LEN:     e.tag = TAG_LEN;
               PH_IDLEN:   e.tag = TAG_IDLEN;
               PH_SVCLEN:  e.tag = TAG_SVCLEN;
               PH_ERR:     e.tag = TAG_ERRCODE;
               PH_INFOLEN: e.tag = TAG_INFOLEN;
               default:    e.tag = TAG_CSUM;
            endcase
            accum = {accum[23:0], b};
            remain = remain - 1;
            word_done = (remain == 0);
         end
         PH_ID, PH_SVC, PH_INFO, PH_PAY: begin
            case (phase)
               PH_ID:   e.tag = TAG_ID;
               PH_SVC:  e.tag = TAG_SVC;
               PH_INFO: e.tag = TAG_INFO;
               default: e.tag = TAG_PAY;
            endcase
            remain = remain - 1;
            if (remain == 0) begin
               case (phase)
                  PH_ID:   start_word(PH_SVCLEN);
                  PH_SVC:  start_word(PH_ERR);
                  PH_INFO: open_field(PH_PAY, flen - idx - PAY_TAIL, PH_CSUM);
                  default: start_word(PH_CSUM);
               endcase
            end
         end
         PH_END: begin
            e.tag = TAG_END;
            e.last = 1'b1;
            if (err_latch != ST_PROGRESS) e.status = err_latch;
            else if (b == end_mk) e.status = ST_OK;
            else e.status = ST_NO_END;
            phase = PH_HUNT;
         end
         default: begin
            // overrun drain: the byte at the declared length closes the frame
            if (idx + 1 >= flen) begin
               e.tag = TAG_END;
               e.last = 1'b1;
               e.status = err_latch;
               phase = PH_HUNT;
            end
         end
      endcase

      // act on a completed big-endian word
      if (word_done) begin
         v = accum;
         case (phase)
            PH_LEN: begin
               if (v < FIXED_BYTES || v > MAX_FRAME) begin
                  e.last = 1'b1;
                  e.status = ST_BAD_LEN;
                  phase = PH_HUNT;
               end else begin
                  flen = v;
                  start_word(PH_IDLEN);
               end
            end
            PH_IDLEN: begin
               if (v == 0 && err_latch == ST_PROGRESS) err_latch = ST_EMPTY_ID;
               if (v > room_after(idx, TAIL_AFTER_IDLEN)) mark_overrun();
               else open_field(PH_ID, v, PH_SVCLEN);
            end
            PH_SVCLEN: begin
               if (v > room_after(idx, TAIL_AFTER_SVCLEN)) mark_overrun();
               else open_field(PH_SVC, v, PH_ERR);
            end
            PH_ERR: start_word(PH_INFOLEN);
            PH_INFOLEN: begin
               if (v > room_after(idx, TAIL_AFTER_INFOLEN)) begin
                  mark_overrun();
               end else if (v != 0) begin
                  phase = PH_INFO;
                  remain = v;
               end else begin
                  open_field(PH_PAY, flen - idx - PAY_TAIL, PH_CSUM);
               end
            end
            default: phase = PH_END;
         endcase
      end

      pos = (phase == PH_HUNT) ? '0 : idx + 1;
      return e;
   endfunction

   // watch both channels and the register port, compare in order
   always @(posedge clock) begin : watch
      echo_type want;
      if (reset) begin
         phase = PH_HUNT;
         err_latch = ST_PROGRESS;
         pos = '0;
         flen = '0;
         accum = '0;
         remain = '0;
         start_mk = START_MARKER_RST;
         end_mk = END_MARKER_RST;
         expected_echoes.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_echoes.size() == 0) begin
               if (error_count < 10)
                  $display("%t unexpected response: byte %02h tag %0d last %0b status %0d",
                           $realtime, rsp_out_byte, rsp_field_tag, rsp_frame_last,
                           rsp_frame_status);
               error_count++;
            end else begin
               want = expected_echoes.pop_front();
               if (rsp_out_byte !== want.data || rsp_field_tag !== want.tag ||
                   rsp_frame_last !== want.last || rsp_frame_status !== want.status) begin
                  if (error_count < 10)
                     $display({"%t mismatch: expected byte %02h tag %0d last %0b status %0d,",
                               " got byte %02h tag %0d last %0b status %0d"},
                              $realtime, want.data, want.tag, want.last, want.status,
                              rsp_out_byte, rsp_field_tag, rsp_frame_last, rsp_frame_status);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_echoes.push_back(parse_byte(req_in_byte));
         // register writes apply from the next byte on
         if (csr_we) begin
            case (csr_index)
               CSR_START_MARKER: start_mk = csr_wdata;
               default:          end_mk = csr_wdata;
            endcase
         end
      end
      pending = expected_echoes.size();
   end

endmodule

[dv/tb_rpc_frame_parser.sv]
`timescale 1ns / 1ps
module tb_rpc_frame_parser;
   import rfp_pkg::*;

   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned STUCK_LIMIT = 2000;

   typedef enum int unsigned {
      FR_CLEAN,
      FR_NO_END,
      FR_ID_OVER,
      FR_SVC_OVER,
      FR_INFO_OVER,
      FR_LEN_OFF
   } flaw_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [7:0]    req_in_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [7:0]    rsp_out_byte;
   logic [3:0]    rsp_field_tag;
   logic          rsp_frame_last;
   logic [2:0]    rsp_frame_status;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_START_MARKER;
   logic [7:0]    csr_wdata = 8'h00;

   int unsigned   error_count;
   int unsigned   pending;
   int unsigned   sent = 0;
   int unsigned   stuck_cycles = 0;
   logic [7:0]    cur_start = START_MARKER_RST;
   logic [7:0]    cur_end = END_MARKER_RST;

   always #6 clock = ~clock;

   rpc_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_field_tag    (rsp_field_tag),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   rfp_echo_checker u_echo_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_field_tag    (rsp_field_tag),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending          (pending)
   );

   // offer one byte, idling now and then, and wait for the transaction
   task automatic push_byte(input logic [7:0] b);
      bit calm;
      calm = (sent >= 600 && sent < 1000);
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
   endtask

   task automatic send_fill(input int unsigned count);
      repeat (count) push_byte(8'($urandom_range(255)));
   endtask

   // a length word beyond the room left; sometimes a huge or negative one
   function automatic logic [31:0] over_len(input logic [31:0] room);
      case ($urandom_range(3))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'h8000_0000 | $urandom;
         default: return room + 1 + $urandom_range(20);
      endcase
   endfunction

   task automatic send_bad_len(input logic [31:0] flen_w);
      push_byte(cur_start);
      send_word(flen_w);
   endtask

   // frame with the given field sizes; the flaw bends one part of it
   task automatic send_frame(input int unsigned n, input int unsigned m,
                             input int unsigned k, input int unsigned p,
                             input flaw_type flaw);
      logic [31:0] flen_w;
      logic [31:0] room;
      logic [31:0] dn;
      logic [31:0] dm;
      logic [31:0] dk;
      logic [7:0]  close;
      flen_w = FIXED_BYTES + n + m + k + p;
      room = flen_w - FIXED_BYTES;
      dn = n;
      dm = m;
      dk = k;
      close = cur_end;
      case (flaw)
         FR_NO_END:    close = cur_end ^ (8'h01 << $urandom_range(7));
         FR_ID_OVER:   dn = over_len(room);
         FR_SVC_OVER:  dm = over_len(room - n);
         FR_INFO_OVER: dk = over_len(room - n - m);
         FR_LEN_OFF: begin
            flen_w = flen_w + $urandom_range(6) - 3;
            if (flen_w < FIXED_BYTES) flen_w = FIXED_BYTES;
         end
         default: ;
      endcase
      push_byte(cur_start);
      send_word(flen_w);
      send_word(dn);
      send_fill(n);
      send_word(dm);
      send_fill(m);
      send_word($urandom);
      send_word(dk);
      send_fill(k + p);
      send_word($urandom);
      push_byte(close);
   endtask

   // well-formed frames half the time, with noise, bad lengths and damaged frames
   task automatic send_random_frame();
      int unsigned pick;
      int unsigned n;
      int unsigned m;
      int unsigned k;
      int unsigned p;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 15) send_fill($urandom_range(1, 4));
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      m = $urandom_range(8);
      k = $urandom_range(8);
      p = $urandom_range(12);
      if ($urandom_range(19) == 0) p = $urandom_range(20, 60);
      if (pick < 8) begin
         case ($urandom_range(2))
            0:       send_bad_len($urandom_range(FIXED_BYTES - 1));
            1:       send_bad_len($urandom_range(MAX_FRAME + 1, MAX_FRAME + 100));
            default: send_bad_len(32'h0100_0000 | $urandom);
         endcase
      end
      else if (pick < 58) send_frame(n, m, k, p, FR_CLEAN);
      else if (pick < 68) send_frame(n, m, k, p, FR_NO_END);
      else if (pick < 75) send_frame(n, m, k, p, FR_ID_OVER);
      else if (pick < 82) send_frame(n, m, k, p, FR_SVC_OVER);
      else if (pick < 90) send_frame(n, m, k, p, FR_INFO_OVER);
      else send_frame(n, m, k, p, FR_LEN_OFF);
   endtask

   // stop offering and wait until every response has been taken
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
      csr_we <= 1'b1;
      csr_index <= CSR_START_MARKER;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_END_MARKER;
      csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_start = s;
      cur_end = e;
   endtask

   // receiver: random stalls, one long hold-off, one stretch with none
   initial begin : receiver
      int unsigned cyc;
      bit          held;
      cyc = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (!held && cyc >= 300 && req_valid) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            cyc += HOLD_OFF_CYCLES;
         end else if (sent >= 600 && sent < 1000) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 16);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_rpc_frame_parser: done, errors");
            $finish;
         end
      end
   end

   // stimulus phases under several marker settings, then the verdict
   initial begin : stimulus
      int unsigned goal;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the byte, both bad-length bounds, shortest frame with empty id
      push_byte(8'h00);
      push_byte(8'hFF);
      send_bad_len(FIXED_BYTES - 1);
      send_bad_len(MAX_FRAME + 1);
      send_frame(0, 0, 0, 0, FR_CLEAN);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph != 0) begin
            drain_block();
            case (ph)
               1:       set_markers(8'h00, 8'hFF);
               2:       set_markers(8'hFF, 8'h00);
               3:       set_markers(8'h7E, 8'h7E);
               default: set_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
         end
         goal = sent + 275;
         while (sent < goal) send_random_frame();
      end

      drain_block();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("tb_rpc_frame_parser: done, clean");
      end else begin
         $display("tb_rpc_frame_parser: done, errors");
      end
      $finish;
   end

endmodule
